>>> hdl/pnc_pkg.sv
`default_nettype none
package pnc_pkg;

    // Channel and code widths
    localparam int CH_W    = 8;
    localparam int CODE_W  = 26;
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int DIST_W  = 18;
    localparam int SQ_W    = 16;

    // Default palette size
    localparam int DEFAULT_DEPTH = 256;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TRUE_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd1;

    // Command codes
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Result constants
    localparam logic [CH_W-1:0]   ALPHA_LIMIT   = 8'd127;
    localparam logic [CODE_W-1:0] TC_OFFSET     = 26'd256;
    localparam logic [CODE_W-1:0] CODE_TRANSP   = '1;
    localparam logic [DIST_W-1:0] DIST_START    = 18'd196608;

    // Pixel word that walks down the cell row
    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    // Palette write broadcast to every cell
    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] idx;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_wr;

    // Running best distance, which trails the pixel by one register
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] score;
    } t_best;

    // Squared absolute difference of two channel values
    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage
`default_nettype wire

>>> hdl/pnc_cell.sv
`default_nettype none
module pnc_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  pnc_pkg::t_wr                      i_wr,
    input  pnc_pkg::t_pix                     i_pix,
    input  pnc_pkg::t_best                    i_best,
    input  wire  [IDX_W-1:0]                  i_best_idx,
    output pnc_pkg::t_pix                     o_pix,
    output pnc_pkg::t_best                    o_best,
    output logic [IDX_W-1:0]                  o_best_idx
);

    logic [pnc_pkg::CH_W-1:0]   r_red;
    logic [pnc_pkg::CH_W-1:0]   r_green;
    logic [pnc_pkg::CH_W-1:0]   r_blue;
    logic [pnc_pkg::SQ_W-1:0]   r_sq_r;
    logic [pnc_pkg::SQ_W-1:0]   r_sq_g;
    logic [pnc_pkg::SQ_W-1:0]   r_sq_b;
    pnc_pkg::t_pix              r_pix;
    pnc_pkg::t_best             r_best;
    logic [IDX_W-1:0]           r_best_idx;
    logic [pnc_pkg::DIST_W-1:0] w_dist;
    logic                       w_hit;

    // Store this cell's palette entry when the write targets it
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.idx) == INDEX)) begin
            r_red   <= i_wr.red;
            r_green <= i_wr.green;
            r_blue  <= i_wr.blue;
        end
    end

    // First half: square the channel differences, forward the pixel
    always_ff @(posedge i_clk) begin
        r_sq_r <= pnc_pkg::sq_diff(r_red, i_pix.red);
        r_sq_g <= pnc_pkg::sq_diff(r_green, i_pix.green);
        r_sq_b <= pnc_pkg::sq_diff(r_blue, i_pix.blue);
        r_pix.red   <= i_pix.red;
        r_pix.green <= i_pix.green;
        r_pix.blue  <= i_pix.blue;
        if (!i_rst_n) begin
            r_pix.valid <= 1'b0;
        end else begin
            r_pix.valid <= i_pix.valid;
        end
    end

    // Second half: sum and compare against the running best
    assign w_dist = pnc_pkg::DIST_W'(r_sq_r) + pnc_pkg::DIST_W'(r_sq_g)
                  + pnc_pkg::DIST_W'(r_sq_b);
    assign w_hit  = i_en && (w_dist < i_best.score);

    // Take over the best when strictly closer, so lower indexes win ties
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_best.score <= w_dist;
            r_best_idx   <= IDX_W'(INDEX);
        end else begin
            r_best.score <= i_best.score;
            r_best_idx   <= i_best_idx;
        end
        if (!i_rst_n) begin
            r_best.valid <= 1'b0;
        end else begin
            r_best.valid <= i_best.valid;
        end
    end

    assign o_pix      = r_pix;
    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule
`default_nettype wire

>>> hdl/palette_nearest_color_top.sv
`default_nettype none
// Nearest palette color lookup. One word is taken at a time. A palette write
// or a classify that resolves without a search (transparent pixel, or
// true-color mode) holds nothing up, and the next word may follow in the
// next cycle unless the output is stalled. A palette search runs the pixel
// down a row of PALETTE_DEPTH cells, one per palette entry, each holding its
// entry and squaring, summing and comparing in two register stages; the pixel
// moves one cell per cycle with the best distance a register behind it, and
// the result passes to the pending result register. No new word is taken
// until the result has been handed to the output register. Configuration
// writes are always ready and must be issued while the block is idle.
module palette_nearest_color_top #(
    parameter int PALETTE_DEPTH = pnc_pkg::DEFAULT_DEPTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_command,
    input  wire  [pnc_pkg::CH_W-1:0]             i_entry_index,
    input  wire  [pnc_pkg::CH_W-1:0]             i_red,
    input  wire  [pnc_pkg::CH_W-1:0]             i_green,
    input  wire  [pnc_pkg::CH_W-1:0]             i_blue,
    input  wire  [pnc_pkg::CH_W-1:0]             i_alpha,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [pnc_pkg::CODE_W-1:0]    o_color_code,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [pnc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [pnc_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic                          r_true_color;
    logic [pnc_pkg::CNT_W-1:0]     r_entries_used;
    pnc_pkg::t_wr                  r_wr;
    pnc_pkg::t_pix                 r_launch;
    logic                          r_seed;
    logic                          r_search;
    logic                          r_pend_valid;
    logic [IDX_W-1:0]              r_pend_idx;
    logic                          r_out_valid;
    logic [pnc_pkg::CODE_W-1:0]    r_out_code;

    logic                          w_accept;
    logic                          w_direct;
    logic                          w_out_free;
    logic [pnc_pkg::CODE_W-1:0]    w_direct_code;
    logic [PALETTE_DEPTH-1:0]      w_en;
    pnc_pkg::t_pix                 w_pix [0:PALETTE_DEPTH];
    pnc_pkg::t_best                w_best [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]              w_best_idx [0:PALETTE_DEPTH];

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_launch.valid || r_search || r_pend_valid || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_direct   = w_accept && (i_command == pnc_pkg::CMD_CLASSIFY)
                      && ((i_alpha < pnc_pkg::ALPHA_LIMIT) || r_true_color);

    // Results that need no search
    always_comb begin
        if (i_alpha < pnc_pkg::ALPHA_LIMIT) begin
            w_direct_code = pnc_pkg::CODE_TRANSP;
        end else begin
            w_direct_code = pnc_pkg::CODE_W'({i_red, i_green, i_blue})
                          + pnc_pkg::TC_OFFSET;
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_true_color   <= 1'b0;
            r_entries_used <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pnc_pkg::CFG_TRUE_COLOR:   r_true_color   <= i_cfg_data[0];
                pnc_pkg::CFG_ENTRIES_USED: r_entries_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Register the palette write and the search launch
    always_ff @(posedge i_clk) begin
        r_wr.idx   <= i_entry_index;
        r_wr.red   <= i_red;
        r_wr.green <= i_green;
        r_wr.blue  <= i_blue;
        r_launch.red   <= i_red;
        r_launch.green <= i_green;
        r_launch.blue  <= i_blue;
        if (!i_rst_n) begin
            r_wr.en        <= 1'b0;
            r_launch.valid <= 1'b0;
            r_seed         <= 1'b0;
        end else begin
            r_wr.en        <= w_accept && (i_command == pnc_pkg::CMD_WRITE);
            r_launch.valid <= w_accept && (i_command == pnc_pkg::CMD_CLASSIFY)
                              && !w_direct;
            r_seed         <= r_launch.valid;
        end
    end

    // Seed the row: pixel at cell zero, starting best a register behind it
    assign w_pix[0]       = r_launch;
    assign w_best[0]      = '{valid: r_seed, score: pnc_pkg::DIST_START};
    assign w_best_idx[0]  = '0;

    // Row of cells, one per palette entry
    for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
        assign w_en[k] = (32'(r_entries_used) > k);

        pnc_cell #(
            .INDEX (k),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en[k]),
            .i_wr       (r_wr),
            .i_pix      (w_pix[k]),
            .i_best     (w_best[k]),
            .i_best_idx (w_best_idx[k]),
            .o_pix      (w_pix[k+1]),
            .o_best     (w_best[k+1]),
            .o_best_idx (w_best_idx[k+1])
        );
    end

    // Track the search and hold its result until the output takes it
    always_ff @(posedge i_clk) begin
        if (w_best[PALETTE_DEPTH].valid) begin
            r_pend_idx <= w_best_idx[PALETTE_DEPTH];
        end
        if (!i_rst_n) begin
            r_search     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_launch.valid) begin
                r_search <= 1'b1;
            end else if (w_best[PALETTE_DEPTH].valid) begin
                r_search <= 1'b0;
            end
            if (w_best[PALETTE_DEPTH].valid) begin
                r_pend_valid <= 1'b1;
            end else if (w_out_free) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_direct) begin
            r_out_code <= w_direct_code;
        end else if (r_pend_valid && w_out_free) begin
            r_out_code <= pnc_pkg::CODE_W'(r_pend_idx);
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_direct || (r_pend_valid && w_out_free)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_color_code = r_out_code;

endmodule
`default_nettype wire
